// ===== rtl/core/bqc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bqc_pkg
// Shared types and constants of the clamped biquad filter.
// ----------------------------------------------------------------------------
package bqc_pkg;

    localparam int COEFF_WIDTH     = 24;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int PROD_COUNT_BITS = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_GAIN_IN_0  = 3'd0,
        REG_GAIN_IN_1  = 3'd1,
        REG_GAIN_IN_2  = 3'd2,
        REG_GAIN_OUT_1 = 3'd3,
        REG_GAIN_OUT_2 = 3'd4,
        REG_LOWER_LIMIT = 3'd5,
        REG_UPPER_LIMIT = 3'd6
    } cfg_index_t;

    typedef enum logic {
        ACT_FILTER = 1'b0,
        ACT_PRESET = 1'b1
    } action_t;

endpackage
`default_nettype wire

// ===== rtl/core/bqc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bqc_if
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------
interface bqc_sample_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic signed [SAMPLE_WIDTH-1:0] preset_output;

    modport source (output valid, output action, output sample, output preset_output,
                    input ready);
    modport sink   (input valid, input action, input sample, input preset_output,
                    output ready);
endinterface

interface bqc_result_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] filtered;
    logic                           limited;

    modport source (output valid, output filtered, output limited, input ready);
    modport sink   (input valid, input filtered, input limited, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bqc_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bqc_cfg
// Coefficient and limit registers, written through a plain write port.
// ----------------------------------------------------------------------------
module bqc_cfg #(
    parameter int SAMPLE_WIDTH        = 16,
    parameter int COEFF_FRACTION_BITS = 20,
    parameter int COEFF_REG_WIDTH     = 24,
    parameter int DATA_WIDTH          = 24
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [bqc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire logic [DATA_WIDTH-1:0]                  cfg_data,
    output logic signed [COEFF_REG_WIDTH-1:0]           gain_in_0,
    output logic signed [COEFF_REG_WIDTH-1:0]           gain_in_1,
    output logic signed [COEFF_REG_WIDTH-1:0]           gain_in_2,
    output logic signed [COEFF_REG_WIDTH-1:0]           gain_out_1,
    output logic signed [COEFF_REG_WIDTH-1:0]           gain_out_2,
    output logic signed [SAMPLE_WIDTH-1:0]              lower_limit,
    output logic signed [SAMPLE_WIDTH-1:0]              upper_limit
);
    import bqc_pkg::*;

    localparam logic signed [COEFF_REG_WIDTH-1:0] UNITY_GAIN =
        COEFF_REG_WIDTH'(1) << COEFF_FRACTION_BITS;
    localparam logic signed [SAMPLE_WIDTH-1:0] MIN_SAMPLE =
        {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] MAX_SAMPLE =
        {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    logic signed [COEFF_REG_WIDTH-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic signed [SAMPLE_WIDTH-1:0]    lo_reg, hi_reg;
    logic signed [COEFF_WIDTH-1:0]     coeff_wr;
    logic signed [COEFF_REG_WIDTH-1:0] coeff_ext;

    assign coeff_wr  = cfg_data[COEFF_WIDTH-1:0];
    assign coeff_ext = COEFF_REG_WIDTH'(coeff_wr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg <= UNITY_GAIN;
            b1_reg <= '0;
            b2_reg <= '0;
            a1_reg <= '0;
            a2_reg <= '0;
            lo_reg <= MIN_SAMPLE;
            hi_reg <= MAX_SAMPLE;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_GAIN_IN_0:   b0_reg <= coeff_ext;
                REG_GAIN_IN_1:   b1_reg <= coeff_ext;
                REG_GAIN_IN_2:   b2_reg <= coeff_ext;
                REG_GAIN_OUT_1:  a1_reg <= coeff_ext;
                REG_GAIN_OUT_2:  a2_reg <= coeff_ext;
                REG_LOWER_LIMIT: lo_reg <= cfg_data[SAMPLE_WIDTH-1:0];
                REG_UPPER_LIMIT: hi_reg <= cfg_data[SAMPLE_WIDTH-1:0];
                default:         ;
            endcase
        end
    end

    assign gain_in_0   = b0_reg;
    assign gain_in_1   = b1_reg;
    assign gain_in_2   = b2_reg;
    assign gain_out_1  = a1_reg;
    assign gain_out_2  = a2_reg;
    assign lower_limit = lo_reg;
    assign upper_limit = hi_reg;

endmodule
`default_nettype wire

// ===== rtl/core/bqc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bqc_datapath
// Multiply-accumulate, rounding, limiting and the four delay registers.
// ----------------------------------------------------------------------------
module bqc_datapath #(
    parameter int SAMPLE_WIDTH        = 16,
    parameter int COEFF_FRACTION_BITS = 20,
    parameter int COEFF_REG_WIDTH     = 24
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               step,
    input  wire logic                               action,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     sample,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     preset_output,
    input  wire logic signed [COEFF_REG_WIDTH-1:0]  gain_in_0,
    input  wire logic signed [COEFF_REG_WIDTH-1:0]  gain_in_1,
    input  wire logic signed [COEFF_REG_WIDTH-1:0]  gain_in_2,
    input  wire logic signed [COEFF_REG_WIDTH-1:0]  gain_out_1,
    input  wire logic signed [COEFF_REG_WIDTH-1:0]  gain_out_2,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     lower_limit,
    input  wire logic signed [SAMPLE_WIDTH-1:0]     upper_limit,
    output logic signed [SAMPLE_WIDTH-1:0]          filtered,
    output logic                                    limited
);
    import bqc_pkg::*;

    localparam int PROD_WIDTH = COEFF_REG_WIDTH + SAMPLE_WIDTH;
    localparam int ACC_WIDTH  = PROD_WIDTH + PROD_COUNT_BITS;
    localparam int Y_WIDTH    = ACC_WIDTH - COEFF_FRACTION_BITS;
    localparam logic signed [ACC_WIDTH-1:0] HALF_LSB =
        ACC_WIDTH'(1) << (COEFF_FRACTION_BITS - 1);

    logic signed [SAMPLE_WIDTH-1:0] in_d1_reg, in_d2_reg, out_d1_reg, out_d2_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_d1_next, in_d2_next, out_d1_next, out_d2_next;

    logic signed [PROD_WIDTH-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [ACC_WIDTH-1:0]  acc, acc_rnd;
    logic signed [Y_WIDTH-1:0]    y_full, lo_ext, hi_ext;
    logic                         over, under;
    logic signed [SAMPLE_WIDTH-1:0] preset_clamped, y_clamped;

    assign p_b0 = gain_in_0  * sample;
    assign p_b1 = gain_in_1  * in_d1_reg;
    assign p_b2 = gain_in_2  * in_d2_reg;
    assign p_a1 = gain_out_1 * out_d1_reg;
    assign p_a2 = gain_out_2 * out_d2_reg;

    assign acc = ACC_WIDTH'(p_b0) + ACC_WIDTH'(p_b1) + ACC_WIDTH'(p_b2)
               - ACC_WIDTH'(p_a1) - ACC_WIDTH'(p_a2);
    assign acc_rnd = acc + HALF_LSB;
    assign y_full  = acc_rnd[ACC_WIDTH-1:COEFF_FRACTION_BITS];

    assign lo_ext = Y_WIDTH'(lower_limit);
    assign hi_ext = Y_WIDTH'(upper_limit);
    assign over   = y_full > hi_ext;
    assign under  = y_full < lo_ext;

    always_comb
    begin
        if (over)
            y_clamped = upper_limit;
        else if (under)
            y_clamped = lower_limit;
        else
            y_clamped = y_full[SAMPLE_WIDTH-1:0];

        preset_clamped = preset_output;
        if (preset_clamped > upper_limit)
            preset_clamped = upper_limit;
        if (preset_clamped < lower_limit)
            preset_clamped = lower_limit;
    end

    always_comb
    begin
        in_d1_next  = in_d1_reg;
        in_d2_next  = in_d2_reg;
        out_d1_next = out_d1_reg;
        out_d2_next = out_d2_reg;
        filtered    = y_clamped;
        limited     = 1'b0;
        if (action == ACT_PRESET)
        begin
            in_d1_next  = sample;
            in_d2_next  = sample;
            out_d1_next = preset_clamped;
            out_d2_next = preset_clamped;
            filtered    = preset_clamped;
        end
        else if (over || under)
        begin
            in_d1_next  = y_clamped;
            in_d2_next  = y_clamped;
            out_d1_next = y_clamped;
            out_d2_next = y_clamped;
            limited     = 1'b1;
        end
        else
        begin
            in_d1_next  = sample;
            in_d2_next  = in_d1_reg;
            out_d1_next = y_clamped;
            out_d2_next = out_d1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_d1_reg  <= '0;
            in_d2_reg  <= '0;
            out_d1_reg <= '0;
            out_d2_reg <= '0;
        end
        else if (step)
        begin
            in_d1_reg  <= in_d1_next;
            in_d2_reg  <= in_d2_next;
            out_d1_reg <= out_d1_next;
            out_d2_reg <= out_d2_next;
        end
    end

    // clamp forces all four delays to one value
    assert property (@(posedge clk) disable iff (!rst_n)
        step && limited |=> in_d1_reg == in_d2_reg && out_d1_reg == out_d2_reg
                            && in_d1_reg == out_d1_reg)
        else $error("delays not equal after clamp");

    assert property (@(posedge clk) disable iff (!rst_n)
        step && action == ACT_PRESET |=> in_d1_reg == in_d2_reg && out_d1_reg == out_d2_reg)
        else $error("delay pairs differ after preset");

endmodule
`default_nettype wire

// ===== rtl/core/biquad_filter_with_clamp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_filter_with_clamp
// Direct-form-I biquad with output limiting and delay preset.
// ----------------------------------------------------------------------------
// Takes one item per clock and returns one result per item, unless a result
// waits unread. An accepted item lands in the input register; when the result
// register is free or being read, the five products, their sum, the rounding
// and the limit check go into the result register. The rate of one item per
// cycle is set by the delay feedback: the delay registers update on the same
// edge as the result register, and the next item reads them straight away.
// While a result waits to be read, a new item is taken only into an empty input
// register. Coefficients are signed with COEFF_FRACTION_BITS fraction bits; the sum is rounded half up.
// ----------------------------------------------------------------------------
module biquad_filter_with_clamp #(
    parameter int SAMPLE_WIDTH        = 16,
    parameter int COEFF_FRACTION_BITS = 20,
    parameter int DATA_WIDTH = (SAMPLE_WIDTH > bqc_pkg::COEFF_WIDTH)
                               ? SAMPLE_WIDTH : bqc_pkg::COEFF_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    bqc_sample_if.sink                               sample_ch,
    bqc_result_if.source                             result_ch,
    input  wire logic                                cfg_we,
    input  wire logic [bqc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [DATA_WIDTH-1:0]               cfg_data
);
    import bqc_pkg::*;

    // b0 must hold 1.0 at reset whatever the binary point
    localparam int COEFF_REG_WIDTH = (COEFF_FRACTION_BITS + 2 > COEFF_WIDTH)
                                     ? COEFF_FRACTION_BITS + 2 : COEFF_WIDTH;

    logic signed [COEFF_REG_WIDTH-1:0] gain_in_0, gain_in_1, gain_in_2;
    logic signed [COEFF_REG_WIDTH-1:0] gain_out_1, gain_out_2;
    logic signed [SAMPLE_WIDTH-1:0]    lower_limit, upper_limit;

    logic                           in_valid_reg, in_valid_next;
    logic                           action_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg, preset_reg;
    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] filtered_reg;
    logic                           limited_reg;
    logic signed [SAMPLE_WIDTH-1:0] filtered_calc;
    logic                           limited_calc;
    logic                           accept, advance;

    bqc_cfg #(
        .SAMPLE_WIDTH        (SAMPLE_WIDTH),
        .COEFF_FRACTION_BITS (COEFF_FRACTION_BITS),
        .COEFF_REG_WIDTH     (COEFF_REG_WIDTH),
        .DATA_WIDTH          (DATA_WIDTH)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .gain_in_0   (gain_in_0),
        .gain_in_1   (gain_in_1),
        .gain_in_2   (gain_in_2),
        .gain_out_1  (gain_out_1),
        .gain_out_2  (gain_out_2),
        .lower_limit (lower_limit),
        .upper_limit (upper_limit)
    );

    bqc_datapath #(
        .SAMPLE_WIDTH        (SAMPLE_WIDTH),
        .COEFF_FRACTION_BITS (COEFF_FRACTION_BITS),
        .COEFF_REG_WIDTH     (COEFF_REG_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .action        (action_reg),
        .sample        (sample_reg),
        .preset_output (preset_reg),
        .gain_in_0     (gain_in_0),
        .gain_in_1     (gain_in_1),
        .gain_in_2     (gain_in_2),
        .gain_out_1    (gain_out_1),
        .gain_out_2    (gain_out_2),
        .lower_limit   (lower_limit),
        .upper_limit   (upper_limit),
        .filtered      (filtered_calc),
        .limited       (limited_calc)
    );

    assign advance         = in_valid_reg && (!out_valid_reg || result_ch.ready);
    assign sample_ch.ready = !in_valid_reg || advance;
    assign accept          = sample_ch.valid && sample_ch.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (result_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= sample_ch.action;
            sample_reg <= sample_ch.sample;
            preset_reg <= sample_ch.preset_output;
        end
        if (advance)
        begin
            filtered_reg <= filtered_calc;
            limited_reg  <= limited_calc;
        end
    end

    assign result_ch.valid    = out_valid_reg;
    assign result_ch.filtered = filtered_reg;
    assign result_ch.limited  = limited_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ch.ready |-> in_valid_reg && out_valid_reg && !result_ch.ready)
        else $error("input stalled without a blocked result");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_valid_reg)
        else $error("accepted item lost from input register");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("computed result not presented");

endmodule
`default_nettype wire
